// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the frame builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside of reset
`define DCFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain invariant, built on the macro above
`define DCFB_INVARIANT(lbl, clk, rst_n, expr, msg) \
    `DCFB_ASSERT(lbl, clk, rst_n, (expr), msg)

`endif

// ----- rtl/core/dcfb_pkg.sv -----
// Types, codes and frame tables for the drive command frame builder
package dcfb_pkg;

    localparam logic [1:0] CMD_START_DIR     = 2'd0;
    localparam logic [1:0] CMD_STOP          = 2'd1;
    localparam logic [1:0] CMD_SET_SPEED     = 2'd2;
    localparam logic [1:0] CMD_START_DEFAULT = 2'd3;

    localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [3:0]  FRAME_MAX        = 4'd13;

    localparam logic [0:0] REG_DEFAULT_ADDR = 1'b0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  drive_address;
        logic [7:0]  direction;
        logic [15:0] speed;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_byte;
    } t_dp_sts;

    function automatic logic [3:0] body_len(input logic [1:0] cmd);
        return (cmd == CMD_START_DIR) ? 4'd11 : 4'd9;
    endfunction

    function automatic logic [3:0] total_len(input logic [1:0] cmd);
        return (cmd inside {CMD_START_DIR, CMD_STOP}) ? 4'd13 : 4'd11;
    endfunction

    function automatic logic [7:0] body_byte(input logic [1:0]  cmd,
                                             input logic [7:0]  addr,
                                             input logic [7:0]  dir,
                                             input logic [15:0] spd,
                                             input logic [3:0]  idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0: b = addr;
            4'd1: b = FUNC_WRITE_MULTI;
            4'd3: b = (cmd == CMD_SET_SPEED) ? 8'h02 : 8'h01;
            4'd5: b = (cmd == CMD_START_DIR) ? 8'h02 : 8'h01;
            4'd6: b = (cmd == CMD_START_DIR) ? 8'h04 : 8'h02;
            4'd7: b = (cmd == CMD_SET_SPEED) ? spd[15:8] : 8'h00;
            4'd8: begin
                case (cmd)
                    CMD_START_DIR: b = dir;
                    CMD_STOP:      b = 8'h20;
                    CMD_SET_SPEED: b = spd[7:0];
                    default:       b = 8'h01;
                endcase
            end
            4'd9:  b = spd[15:8];
            4'd10: b = spd[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte of CRC-16/Modbus, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/drive_command_frame_builder.sv -----
// Drive command frame builder top level: config register and module wiring
//
// Each accepted command yields one Modbus RTU write-multiple-registers request,
// one byte per output word, CRC-16/Modbus appended low byte first and last set
// on the final byte. Start-with-direction and stop frames are 13 bytes, set
// speed and plain start frames 11 bytes. The byte counter emits one byte per
// cycle into the output register unless the output stalls, and the CRC unit
// folds in each body byte as it is emitted; the next command is taken in the
// cycle the final byte enters the output register. The default drive address
// register (byte address 0, reset 1) is used by plain start and should be
// written only while no frame is in flight.

module drive_command_frame_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcfb_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcfb_pkg::t_out_word o_out_word,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    logic [7:0]        r_default_addr;
    dcfb_pkg::t_dp_cmd w_dp_cmd;
    dcfb_pkg::t_dp_sts w_dp_sts;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == dcfb_pkg::REG_DEFAULT_ADDR) ?
                      {24'h000000, r_default_addr} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_addr <= 8'h01;
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     (i_paddr[2] == dcfb_pkg::REG_DEFAULT_ADDR)) begin
            r_default_addr <= i_pwdata[7:0];
        end
    end

    dcfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (w_dp_cmd),
        .i_dp_sts    (w_dp_sts)
    );

    dcfb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (w_dp_cmd),
        .o_dp_sts       (w_dp_sts),
        .i_in_word      (i_in_word),
        .i_default_addr (r_default_addr),
        .o_out_word     (o_out_word)
    );

endmodule

// ----- rtl/core/dcfb_ctrl.sv -----
// Frame builder controller: command intake and byte sequencing
`include "assert_macros.svh"

module dcfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dcfb_pkg::t_dp_cmd o_dp_cmd,
    input  dcfb_pkg::t_dp_sts i_dp_sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load, w_done, w_accept;

    // output register free or being drained this cycle
    assign w_load   = (r_state == ST_SEND) && (!r_out_valid || !i_out_stall);
    assign w_done   = w_load && i_dp_sts.last_byte;
    // next command may enter as the final byte goes out
    assign o_in_stall = !((r_state == ST_IDLE) || w_done);
    assign w_accept = i_in_valid && !o_in_stall;

    assign o_dp_cmd.start = w_accept;
    assign o_dp_cmd.emit  = w_load;
    assign o_out_valid    = r_out_valid;

    always_comb begin
        n_state = r_state;
        if (w_accept) begin
            n_state = ST_SEND;
        end else if (w_done) begin
            n_state = ST_IDLE;
        end
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `DCFB_ASSERT(a_accept_sends, i_clk, i_rst_n, w_accept |=> (r_state == ST_SEND), "accepted command did not start a frame")
    `DCFB_ASSERT(a_done_idles, i_clk, i_rst_n, (w_done && !w_accept) |=> (r_state == ST_IDLE), "frame end did not return to idle")
    `DCFB_INVARIANT(a_no_idle_load, i_clk, i_rst_n, !((r_state == ST_IDLE) && w_load), "byte loaded while idle")

endmodule

// ----- rtl/core/dcfb_datapath.sv -----
// Frame builder datapath: command latch, byte select, CRC and output word
`include "assert_macros.svh"

module dcfb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcfb_pkg::t_dp_cmd   i_dp_cmd,
    output dcfb_pkg::t_dp_sts   o_dp_sts,
    input  dcfb_pkg::t_in_word  i_in_word,
    input  logic [7:0]          i_default_addr,
    output dcfb_pkg::t_out_word o_out_word
);

    logic [1:0]          r_cmd;
    logic [7:0]          r_addr;
    logic [7:0]          r_dir;
    logic [15:0]         r_speed;
    logic [3:0]          r_idx;
    logic [15:0]         r_crc;
    dcfb_pkg::t_out_word r_out_word;

    logic [3:0] w_body;
    logic [3:0] w_total;
    logic [7:0] w_byte;
    logic       w_in_body;

    assign w_body    = dcfb_pkg::body_len(r_cmd);
    assign w_total   = dcfb_pkg::total_len(r_cmd);
    assign w_in_body = (r_idx < w_body);

    always_comb begin
        if (w_in_body) begin
            w_byte = dcfb_pkg::body_byte(r_cmd, r_addr, r_dir, r_speed, r_idx);
        end else if (r_idx == w_body) begin
            w_byte = r_crc[7:0];
        end else if (r_idx == (w_body + 4'd1)) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = 8'h00;     // stop frame pad
        end
    end

    assign o_dp_sts.last_byte = (r_idx == (w_total - 4'd1));
    assign o_out_word         = r_out_word;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_out_word.tx_byte <= w_byte;
            r_out_word.last    <= o_dp_sts.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_cmd   <= i_in_word.cmd;
            r_addr  <= (i_in_word.cmd == dcfb_pkg::CMD_START_DEFAULT) ?
                       i_default_addr : i_in_word.drive_address;
            r_dir   <= i_in_word.direction;
            r_speed <= i_in_word.speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
            r_crc <= dcfb_pkg::CRC_INIT;
        end else if (i_dp_cmd.start) begin
            r_idx <= 4'd0;
            r_crc <= dcfb_pkg::CRC_INIT;
        end else if (i_dp_cmd.emit) begin
            r_idx <= r_idx + 4'd1;
            if (w_in_body) begin
                r_crc <= dcfb_pkg::crc_byte(r_crc, w_byte);
            end
        end
    end

    `DCFB_INVARIANT(a_idx_range, i_clk, i_rst_n, r_idx <= dcfb_pkg::FRAME_MAX, "byte index past frame end")

endmodule

// ----- dv/tb_drive_command_frame_builder.sv -----
// Self-checking testbench for the drive command frame builder
`timescale 1ns / 1ps

module tb_drive_command_frame_builder;

    localparam logic [2:0] ADDR_DFLT_DRIVE = {dcfb_pkg::REG_DEFAULT_ADDR, 2'b00};
    localparam logic [2:0] ADDR_NO_REG     = 3'd4;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         PHASE_ITEMS     = 90;

    typedef logic [12:0][7:0] t_frame;

    // fix_len of zero: frame shape is left to the predictor alone
    typedef struct packed {
        dcfb_pkg::t_in_word w;
        logic [3:0]         fix_len;
        logic [7:0]         fix_first;
    } t_cmd_row;

    localparam int N_ROWS = 20;
    localparam t_cmd_row CMD_ROWS [N_ROWS] = '{
        '{'{dcfb_pkg::CMD_START_DEFAULT, 8'h00, 8'h00, 16'h0000}, 4'd11, 8'h01},
        '{'{dcfb_pkg::CMD_START_DEFAULT, 8'hFF, 8'hFF, 16'hFFFF}, 4'd11, 8'h01},
        '{'{dcfb_pkg::CMD_START_DIR,     8'h00, 8'h00, 16'h0000}, 4'd13, 8'h00},
        '{'{dcfb_pkg::CMD_START_DIR,     8'hFF, 8'hFF, 16'hFFFF}, 4'd13, 8'hFF},
        '{'{dcfb_pkg::CMD_START_DIR,     8'h55, 8'hAA, 16'h5A5A}, 4'd13, 8'h55},
        '{'{dcfb_pkg::CMD_START_DIR,     8'hAA, 8'h55, 16'hA5A5}, 4'd13, 8'hAA},
        '{'{dcfb_pkg::CMD_STOP,          8'h00, 8'h00, 16'h0000}, 4'd13, 8'h00},
        '{'{dcfb_pkg::CMD_STOP,          8'hFF, 8'hFF, 16'hFFFF}, 4'd13, 8'hFF},
        '{'{dcfb_pkg::CMD_STOP,          8'h12, 8'h34, 16'h5678}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_SET_SPEED,     8'h00, 8'h00, 16'h0000}, 4'd11, 8'h00},
        '{'{dcfb_pkg::CMD_SET_SPEED,     8'hFF, 8'hFF, 16'hFFFF}, 4'd11, 8'hFF},
        '{'{dcfb_pkg::CMD_SET_SPEED,     8'h3C, 8'hC3, 16'h8001}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_SET_SPEED,     8'h01, 8'h00, 16'h00FF}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_START_DIR,     8'h01, 8'h80, 16'h0100}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_START_DIR,     8'h7F, 8'h01, 16'hFF00}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_START_DEFAULT, 8'h5A, 8'h3C, 16'h1234}, 4'd11, 8'h01},
        '{'{dcfb_pkg::CMD_STOP,          8'h01, 8'h00, 16'h0000}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_START_DIR,     8'h10, 8'h20, 16'h1020}, 4'd0,  8'h00},
        '{'{dcfb_pkg::CMD_STOP,          8'h80, 8'h7F, 16'h8000}, 4'd13, 8'h80},
        '{'{dcfb_pkg::CMD_SET_SPEED,     8'h80, 8'h7F, 16'h7FFF}, 4'd0,  8'h00}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    dcfb_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    dcfb_pkg::t_out_word o_out_word;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [2:0]          i_paddr;
    logic [31:0]         i_pwdata;
    logic [31:0]         o_prdata;
    logic                o_pready;

    dcfb_pkg::t_out_word pending_bytes [$];
    logic [7:0]          dflt_drive_addr;
    int                  mismatch_count;
    bit                  no_idle;

    drive_command_frame_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_pready    (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_drive_command_frame_builder: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // bit-serial form of the reflected CRC-16/Modbus
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ 16'hA001;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Builds the request frame for one command, returns its byte count
    function automatic int predict_frame(input dcfb_pkg::t_in_word w, input logic [7:0] dflt,
                                         output t_frame fr);
        logic [15:0] crc;
        int          body;
        int          total;
        fr    = '0;
        fr[1] = dcfb_pkg::FUNC_WRITE_MULTI;
        case (w.cmd)
            dcfb_pkg::CMD_START_DIR: begin
                fr[0]  = w.drive_address;
                fr[3]  = 8'h01;
                fr[5]  = 8'h02;
                fr[6]  = 8'h04;
                fr[8]  = w.direction;
                fr[9]  = w.speed[15:8];
                fr[10] = w.speed[7:0];
                body   = 11;
                total  = 13;
            end
            dcfb_pkg::CMD_STOP: begin
                fr[0] = w.drive_address;
                fr[3] = 8'h01;
                fr[5] = 8'h01;
                fr[6] = 8'h02;
                fr[8] = 8'h20;
                body  = 9;
                total = 13;     // two zero pad bytes follow the CRC
            end
            dcfb_pkg::CMD_SET_SPEED: begin
                fr[0] = w.drive_address;
                fr[3] = 8'h02;
                fr[5] = 8'h01;
                fr[6] = 8'h02;
                fr[7] = w.speed[15:8];
                fr[8] = w.speed[7:0];
                body  = 9;
                total = 11;
            end
            default: begin
                fr[0] = dflt;
                fr[3] = 8'h01;
                fr[5] = 8'h01;
                fr[6] = 8'h02;
                fr[8] = 8'h01;
                body  = 9;
                total = 11;
            end
        endcase
        crc = dcfb_pkg::CRC_INIT;
        for (int i = 0; i < body; i++) begin
            crc = crc16_step(crc, fr[i]);
        end
        fr[body]     = crc[7:0];
        fr[body + 1] = crc[15:8];
        return total;
    endfunction

    // Output side is handled before input so a fresh frame never matches a word
    // leaving on the same edge
    always @(posedge i_clk) begin : scoreboard
        t_frame              fr;
        int                  n;
        dcfb_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch("word with none pending", 32'(o_out_word), 32'd0);
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_out_word.tx_byte !== want.tx_byte) begin
                        report_mismatch("tx_byte", 32'(o_out_word.tx_byte), 32'(want.tx_byte));
                    end
                    if (o_out_word.last !== want.last) begin
                        report_mismatch("last", 32'(o_out_word.last), 32'(want.last));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                n = predict_frame(i_in_word, dflt_drive_addr, fr);
                for (int i = 0; i < n; i++) begin
                    pending_bytes.push_back(dcfb_pkg::t_out_word'{fr[i], i == n - 1});
                end
            end
        end
    end

    // Output stall: random bursts, with occasional long clear stretches; none once no_idle is set
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input dcfb_pkg::t_in_word w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (addr == ADDR_DFLT_DRIVE) begin
            dflt_drive_addr = data[7:0];
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        @(negedge i_clk);
        i_psel   <= 1'b1;
        i_pwrite <= 1'b0;
        i_paddr  <= addr;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (o_prdata !== want) begin
            report_mismatch("prdata", o_prdata, want);
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    initial begin : stimulus
        t_frame             fr;
        int                 n;
        logic [31:0]        val;
        dcfb_pkg::t_in_word w;
        mismatch_count  = 0;
        no_idle         = 1'b0;
        dflt_drive_addr = 8'h01;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_psel     = 1'b0;
        i_penable  = 1'b0;
        i_pwrite   = 1'b0;
        i_paddr    = '0;
        i_pwdata   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_check(ADDR_DFLT_DRIVE, 32'h0000_0001);

        for (int r = 0; r < N_ROWS; r++) begin
            if (CMD_ROWS[r].fix_len != 4'd0) begin
                n = predict_frame(CMD_ROWS[r].w, dflt_drive_addr, fr);
                if (n != int'(CMD_ROWS[r].fix_len)) begin
                    report_mismatch("frame length", 32'(n), 32'(CMD_ROWS[r].fix_len));
                end
                if (fr[0] !== CMD_ROWS[r].fix_first) begin
                    report_mismatch("address byte", 32'(fr[0]), 32'(CMD_ROWS[r].fix_first));
                end
            end
            send_word(CMD_ROWS[r].w);
        end

        // a write with no register behind it must leave the address alone
        wait_idle();
        apb_write(ADDR_NO_REG, 32'h0000_0055);
        apb_check(ADDR_DFLT_DRIVE, 32'h0000_0001);

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0:       val = 32'hFFFF_FFFF;
                1:       val = 32'h0000_0000;
                default: val = $urandom();
            endcase
            apb_write(ADDR_DFLT_DRIVE, val);
            apb_check(ADDR_DFLT_DRIVE, {24'h0, val[7:0]});
            if (p == 4) begin
                no_idle = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                w.cmd           = 2'($urandom_range(0, 3));
                w.drive_address = 8'($urandom());
                w.direction     = 8'($urandom());
                w.speed         = 16'($urandom());
                send_word(w);
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_drive_command_frame_builder: clean");
        end else begin
            $display("tb_drive_command_frame_builder: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dcfb_pkg.sv
rtl/core/dcfb_ctrl.sv
rtl/core/dcfb_datapath.sv
rtl/core/drive_command_frame_builder.sv
dv/tb_drive_command_frame_builder.sv
